[design/bda_pkg.sv]
// shared types and constants for the binary to decimal ascii converter
// no dependencies; imported by every module of the block
package bda_pkg;

    localparam int unsigned CONV_BITS       = 64;
    localparam int unsigned BCD_DIGITS      = 20;
    localparam int unsigned DEF_QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // operation codes
    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    // classified item handed from front to back
    typedef struct packed {
        logic                 neg;
        logic [CONV_BITS-1:0] mag;
    } t_work;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_SIGN,
        S_EMIT
    } t_state;

endpackage

[design/binary_to_decimal_ascii.sv]
// binary to decimal ascii converter, 64-bit, signed or unsigned reading
// top level; depends on bda_pkg, bda_front, bda_queue and bda_back
//
// usage:
//   input channel is a queue write port: an item (i_value, i_operation) is
//   taken at a rising edge with push high and full low. i_operation selects
//   unsigned (0) or two's complement (1) reading of i_value.
//   result channel is a queue read port: while empty is low the oldest
//   character waits on o_character/o_last and is taken at an edge with pop
//   high. one item gives 1 to 20 characters, an optional '-' then the digits
//   most significant first without leading zeros; o_last marks the final one.
// timing:
//   front stage and queue are registered; the shared double dabble unit in
//   the back converts one magnitude bit per cycle, an optional sign follows and
//   the digit scan does one bcd digit per cycle unless the receiver stalls.
//   on an idle block the first character appears once the conversion is done,
//   later the fewer digits there are; the back takes the next item only after
//   the final character of the last one is placed on the output, and the front
//   and queue keep accepting up to QUEUE_DEPTH + 1 items meanwhile.
// reset and stalls:
//   synchronous active-low reset empties the front, queue and output; no
//   clearing pass is needed. a stalled receiver holds the output character
//   and the back waits; full rises once the queue and front stage are taken.
module binary_to_decimal_ascii #(
    parameter int unsigned QUEUE_DEPTH = bda_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bda_pkg::CONV_BITS-1:0] i_value,
    input  logic                          i_operation,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    o_character,
    output logic                          o_last
);
    import bda_pkg::*;

    logic  w_q_push, w_q_full, w_q_pop, w_q_empty;
    t_work w_q_in, w_q_out;

    // sign and magnitude split
    bda_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_value     (i_value),
        .i_operation (i_operation),
        .o_q_push    (w_q_push),
        .o_q_data    (w_q_in),
        .i_q_full    (w_q_full)
    );

    // decoupling queue
    bda_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    // conversion and character output
    bda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_data    (w_q_out),
        .i_q_empty   (w_q_empty),
        .o_q_pop     (w_q_pop),
        .empty       (empty),
        .pop         (pop),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule

[design/bda_front.sv]
// front end: takes input items, splits sign and magnitude, holds one item
// depends on bda_pkg
module bda_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [bda_pkg::CONV_BITS-1:0] i_value,
    input  logic                        i_operation,
    output logic                        o_q_push,
    output bda_pkg::t_work              o_q_data,
    input  logic                        i_q_full
);
    import bda_pkg::*;

    logic   r_valid, n_valid;
    t_work  r_work, n_work;
    logic   w_ready;
    logic   w_neg;

    // stage is free when empty or when the queue takes its item now
    assign w_ready  = !r_valid || !i_q_full;
    assign full     = !w_ready;
    assign o_q_push = r_valid;
    assign o_q_data = r_work;

    // sign and magnitude of the incoming word
    assign w_neg = (i_operation == OP_SIGNED) && i_value[CONV_BITS-1];

    always_comb begin
        n_valid = r_valid;
        n_work  = r_work;
        if (r_valid && !i_q_full) begin
            n_valid = 1'b0;
        end
        if (push && w_ready) begin
            n_valid    = 1'b1;
            n_work.neg = w_neg;
            n_work.mag = w_neg ? (~i_value + {{(CONV_BITS-1){1'b0}}, 1'b1}) : i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_work <= n_work;
    end

endmodule

[design/bda_queue.sv]
// short register queue between the front and the back
// depends on bda_pkg for the item type
module bda_queue #(
    parameter int unsigned DEPTH = bda_pkg::DEF_QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bda_pkg::t_work i_data,
    output logic           o_full,
    input  logic           i_pop,
    output bda_pkg::t_work o_data,
    output logic           o_empty
);
    import bda_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_work           r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({w_do_push, w_do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/bda_back.sv]
// back end: iterative double dabble, then character emission
// depends on bda_pkg
module bda_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bda_pkg::t_work i_q_data,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    output logic           empty,
    input  logic           pop,
    output logic [7:0]     o_character,
    output logic           o_last
);
    import bda_pkg::*;

    localparam int unsigned BCD_BITS = 4 * BCD_DIGITS;
    localparam int unsigned IW       = $clog2(CONV_BITS);
    localparam int unsigned DW       = $clog2(BCD_DIGITS);

    t_state                r_state, n_state;
    logic [CONV_BITS-1:0]  r_mag, n_mag;
    logic [BCD_BITS-1:0]   r_bcd, n_bcd;
    logic                  r_neg, n_neg;
    logic [IW-1:0]         r_iter, n_iter;
    logic [DW-1:0]         r_pos, n_pos;
    logic                  r_started, n_started;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_char, n_char;
    logic                  r_last, n_last;
    logic                  w_slot_free;
    logic [3:0]            w_top;
    logic                  w_final_pos;
    logic [BCD_BITS-1:0]   w_adj;

    // add three to every digit of five or more before the shift
    function automatic logic [BCD_BITS-1:0] dabble_adjust(input logic [BCD_BITS-1:0] bcd);
        logic [BCD_BITS-1:0] res;
        res = bcd;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (bcd[4*k +: 4] >= 4'd5) begin
                res[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
            end
        end
        return res;
    endfunction

    assign empty       = !r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;
    assign w_slot_free = !r_out_valid || pop;
    assign w_top       = r_bcd[BCD_BITS-1 -: 4];
    assign w_final_pos = (r_pos == DW'(BCD_DIGITS - 1));
    assign w_adj       = dabble_adjust(r_bcd);

    // sequencer and output register
    always_comb begin
        n_state     = r_state;
        n_mag       = r_mag;
        n_bcd       = r_bcd;
        n_neg       = r_neg;
        n_iter      = r_iter;
        n_pos       = r_pos;
        n_started   = r_started;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_last      = r_last;
        o_q_pop     = 1'b0;
        if (r_out_valid && pop) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_mag   = i_q_data.mag;
                    n_neg   = i_q_data.neg;
                    n_bcd   = '0;
                    n_iter  = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd  = {w_adj[BCD_BITS-2:0], r_mag[CONV_BITS-1]};
                n_mag  = {r_mag[CONV_BITS-2:0], 1'b0};
                n_iter = r_iter + 1'b1;
                n_pos     = '0;
                n_started = 1'b0;
                if (r_iter == IW'(CONV_BITS - 1)) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_char      = CH_MINUS;
                    n_last      = 1'b0;
                    n_state     = S_EMIT;
                end
            end
            S_EMIT: begin
                // leading zeros are skipped, the units digit always goes out
                if (r_started || (w_top != 4'd0) || w_final_pos) begin
                    if (w_slot_free) begin
                        n_out_valid = 1'b1;
                        n_char      = CH_ZERO + {4'd0, w_top};
                        n_last      = w_final_pos;
                        n_started   = 1'b1;
                        n_bcd       = {r_bcd[BCD_BITS-5:0], 4'd0};
                        n_pos       = r_pos + 1'b1;
                        if (w_final_pos) begin
                            n_state = S_IDLE;
                        end
                    end
                end else begin
                    n_bcd = {r_bcd[BCD_BITS-5:0], 4'd0};
                    n_pos = r_pos + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_mag     <= n_mag;
        r_bcd     <= n_bcd;
        r_neg     <= n_neg;
        r_iter    <= n_iter;
        r_pos     <= n_pos;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    // the conversion runs its full count before anything is emitted
    a_conv_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CONV) && (r_iter != IW'(CONV_BITS - 1)) |=> (r_state == S_CONV))
        else $error("conversion left before its last iteration");

    // only a minus sign or a digit ever reaches the output
    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_char == CH_MINUS) || ((r_char >= CH_ZERO) && (r_char <= CH_NINE)))
        else $error("illegal character on the output");

    // a minus sign is never the final character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_char == CH_MINUS) |-> !r_last)
        else $error("minus sign marked as last");

    // a waiting character holds while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !pop |=> r_out_valid && $stable(r_char) && $stable(r_last))
        else $error("stalled character changed");

endmodule
